>>> design/wrst_pkg.sv
// wrst_pkg: types and constants shared by the waiting-room slot table.
// Holds the transaction structs, opcodes and status codes.
// No dependencies.
package wrst_pkg;

    // opcodes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // status codes
    localparam logic [2:0] ST_SEATED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_SERVED  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // a slot holding this id is free
    localparam logic [15:0] ID_FREE = 16'd0;

    // chairs_in_use after reset
    localparam logic [4:0] CHAIRS_RESET = 5'd16;

    typedef struct packed {
        logic        opcode;
        logic [15:0] client_id;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] served_id;
        logic [4:0]  occupied;
        logic        wake_server;
    } result_t;

endpackage

>>> design/waiting_room_slot_table.sv
// waiting_room_slot_table: top level of the waiting-room slot table.
// Holds the chairs_in_use register and joins the sequencer to the slot memory.
// Depends on wrst_pkg, wrst_mem, wrst_seq.
//
//  channel   ports                 transfer
//  --------  --------------------  --------------------------------------
//  command   start, busy, req      taken at the edge with start & !busy
//  result    done, result          one cycle, taken at the closing edge
//  config    cfg_we, cfg_data      chairs_in_use written when cfg_we high
//
// One transaction at a time. An arrive scans slots 0..min(chairs,SLOTS)-1
// and stops at the first free one; a serve scans all SLOTS slots. The
// memory gives one read per cycle with registered read data, and each
// read is compared while the scan goes on issuing; an arrive with id 0
// skips the scan. The write-back shares the finishing cycle. Reset clears
// state and marks every slot free at once through per-slot valid flags;
// no clearing pass. Results cannot be stalled.
module waiting_room_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  wrst_pkg::request_t req,
    output logic               busy,
    output logic               done,
    output wrst_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam logic [LW-1:0] SLOTS_LW = LW'(SLOTS);

    logic [4:0]    chairs_reg;
    logic [LW-1:0] chairs_ext;
    logic [CW-1:0] limit;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chairs_reg <= wrst_pkg::CHAIRS_RESET;
        end
        else if (cfg_we)
        begin
            chairs_reg <= cfg_data;
        end
    end

    // chairs above the built slot count act as SLOTS
    assign chairs_ext = LW'(chairs_reg);
    assign limit      = (chairs_ext > SLOTS_LW) ? CW'(SLOTS) : chairs_ext[CW-1:0];

    wrst_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    wrst_seq #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .limit   (limit),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

>>> design/wrst_mem.sv
// wrst_mem: slot id storage, one write and one read port, registered read.
// Per-entry valid flags make unwritten entries read as free after reset.
// Depends on wrst_pkg.
module wrst_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [15:0]      data_reg;
    logic             data_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                data_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = data_valid_reg ? data_reg : wrst_pkg::ID_FREE;

endmodule

>>> design/wrst_seq.sv
// wrst_seq: sequencer that scans the slot memory, one read per cycle,
// and writes back the chosen slot; keeps occupancy and server state.
// Depends on wrst_pkg.
module wrst_seq #(
    parameter int SLOTS = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  wrst_pkg::request_t  req,
    input  logic [CW-1:0]       limit,
    output logic                busy,
    output logic                done,
    output wrst_pkg::result_t   result,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [15:0]         rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [15:0]         wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int SW = (AW > 4) ? AW : 4;
    localparam logic [CW-1:0] SLOTS_CW = CW'(SLOTS);

    logic [1:0]        state_reg, state_next;
    logic              op_reg;
    logic [15:0]       id_reg;
    logic [CW-1:0]     range_reg;
    logic [CW-1:0]     issue_idx_reg, issue_idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg;
    logic              found_reg, found_next;
    logic [15:0]       best_reg, best_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [4:0]        occupied_reg, occupied_next;
    logic              server_busy_reg, server_busy_next;
    logic              done_reg;
    wrst_pkg::result_t result_reg, result_next;
    logic              issue;
    logic [SW-1:0]     slot_ext;

    // compare stage: data of the read issued last cycle
    always_comb
    begin
        found_next    = found_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (pend_reg)
        begin
            if (op_reg == wrst_pkg::OP_ARRIVE)
            begin
                if (!found_reg && rd_data == wrst_pkg::ID_FREE)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                end
            end
            else if (rd_data != wrst_pkg::ID_FREE && (!found_reg || rd_data < best_reg))
            begin
                found_next    = 1'b1;
                best_next     = rd_data;
                best_idx_next = pend_idx_reg;
            end
        end
    end

    // arrive stops issuing once a free slot is seen
    assign issue = (state_reg == S_SCAN) && (issue_idx_reg < range_reg) &&
                   !(op_reg == wrst_pkg::OP_ARRIVE && found_next);
    assign rd_en          = issue;
    assign rd_addr        = issue_idx_reg[AW-1:0];
    assign pend_next      = issue;
    assign issue_idx_next = issue_idx_reg + CW'(1);

    assign slot_ext = SW'(best_idx_reg);

    // next state; write-back and result in the finishing cycle
    always_comb
    begin
        state_next       = state_reg;
        wr_en            = 1'b0;
        wr_addr          = best_idx_reg;
        wr_data          = wrst_pkg::ID_FREE;
        occupied_next    = occupied_reg;
        server_busy_next = server_busy_reg;
        result_next      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.opcode == wrst_pkg::OP_ARRIVE && req.client_id == wrst_pkg::ID_FREE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                if (op_reg == wrst_pkg::OP_ARRIVE)
                begin
                    if (id_reg == wrst_pkg::ID_FREE)
                    begin
                        result_next.status = wrst_pkg::ST_INVALID;
                    end
                    else if (found_reg)
                    begin
                        wr_en                   = 1'b1;
                        wr_data                 = id_reg;
                        occupied_next           = occupied_reg + 5'd1;
                        result_next.status      = wrst_pkg::ST_SEATED;
                        result_next.slot        = slot_ext[3:0];
                        result_next.wake_server = !server_busy_reg;
                    end
                    else
                    begin
                        result_next.status = wrst_pkg::ST_FULL;
                    end
                end
                else if (found_reg)
                begin
                    wr_en                 = 1'b1;
                    occupied_next         = occupied_reg - 5'd1;
                    server_busy_next      = 1'b1;
                    result_next.status    = wrst_pkg::ST_SERVED;
                    result_next.slot      = slot_ext[3:0];
                    result_next.served_id = best_reg;
                end
                else
                begin
                    server_busy_next   = 1'b0;
                    result_next.status = wrst_pkg::ST_EMPTY;
                end
                result_next.occupied = occupied_next;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            occupied_reg    <= 5'd0;
            server_busy_reg <= 1'b0;
            done_reg        <= 1'b0;
            issue_idx_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            occupied_reg    <= occupied_next;
            server_busy_reg <= server_busy_next;
            done_reg        <= (state_reg == S_DONE);
            if (state_reg == S_IDLE)
            begin
                pend_reg      <= 1'b0;
                found_reg     <= 1'b0;
                issue_idx_reg <= '0;
            end
            else
            begin
                pend_reg  <= pend_next;
                found_reg <= found_next;
                if (issue)
                begin
                    issue_idx_reg <= issue_idx_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg    <= req.opcode;
            id_reg    <= req.client_id;
            range_reg <= (req.opcode == wrst_pkg::OP_SERVE) ? SLOTS_CW : limit;
        end
        pend_idx_reg <= issue_idx_reg[AW-1:0];
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
